// ===== hdl/srfr_pkg.sv =====
// srfr_pkg: shared types and constants for the servo reply frame receiver
// used by srfr_emitter and servo_reply_frame_receiver; no dependencies
package srfr_pkg;

  localparam int unsigned MaxFrameDef = 16;
  localparam int unsigned LenW        = 5;
  localparam int unsigned TickW       = 20;

  localparam logic [7:0] HdrByte = 8'hFB;

  // register reset values, and the shortest accepted frame length
  localparam logic [7:0]       DevAddrRst   = 8'd1;
  localparam logic [7:0]       ExpFuncRst   = 8'd49;
  localparam logic [LenW-1:0]  FrameLenRst  = 5'd10;
  localparam logic [TickW-1:0] TimeoutRst   = 20'd5000;
  localparam logic [LenW-1:0]  MinLen       = 5'd4;

  typedef enum logic [1:0] {
    FuncStart = 2'd0,
    FuncByte  = 2'd1,
    FuncTick  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    RegDevAddr  = 2'd0,
    RegExpFunc  = 2'd1,
    RegFrameLen = 2'd2,
    RegTimeout  = 2'd3
  } reg_e;

  // request to start a result run
  typedef struct packed {
    logic            start;
    logic            tmo;
    logic            bank;
    logic [LenW-1:0] len;
  } run_req_t;

endpackage

// ===== hdl/srfr_emitter.sv =====
// srfr_emitter: ping-pong frame buffer and result run sequencer
// depends on srfr_pkg
module srfr_emitter #(
  parameter int unsigned MAX_FRAME = srfr_pkg::MaxFrameDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  srfr_pkg::run_req_t        run_i,
  input  logic                      wr_en_i,
  input  logic                      wr_bank_i,
  input  logic [srfr_pkg::LenW-1:0] wr_idx_i,
  input  logic [7:0]                wr_data_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      outcome_o,
  output logic [7:0]                frame_byte_o,
  output logic [3:0]                byte_position_o,
  output logic                      last_of_run_o
);

  localparam int unsigned AW    = $clog2(MAX_FRAME);
  localparam int unsigned Depth = 2 ** (AW + 1);

  logic [7:0] mem [Depth];

  logic                      busy_q;
  logic                      bank_q;
  logic                      tmo_q;
  logic [srfr_pkg::LenW-1:0] pos_q;
  logic [srfr_pkg::LenW-1:0] len_q;
  logic                      out_valid_q;

  logic [7:0]                rd_data_q;
  logic                      otmo_q;
  logic                      olast_q;
  logic [srfr_pkg::LenW-1:0] opos_q;

  logic          adv;
  logic          run_last;
  logic [AW:0]   waddr;
  logic [AW:0]   raddr;

  assign adv      = busy_q && (!out_valid_q || out_ready_i);
  assign run_last = (pos_q == (len_q - 5'd1));
  assign waddr    = {wr_bank_i, AW'(wr_idx_i)};
  assign raddr    = {bank_q, AW'(pos_q)};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[waddr] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_data_q <= mem[raddr];
      otmo_q    <= tmo_q;
      olast_q   <= run_last;
      opos_q    <= pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      bank_q      <= 1'b0;
      tmo_q       <= 1'b0;
      pos_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (run_i.start) begin
        busy_q <= 1'b1;
        pos_q  <= '0;
        len_q  <= run_i.len;
        bank_q <= run_i.bank;
        tmo_q  <= run_i.tmo;
      end else if (adv) begin
        pos_q <= pos_q + 5'd1;
        if (run_last) begin
          busy_q <= 1'b0;
        end
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign busy_o          = busy_q;
  assign out_valid_o     = out_valid_q;
  assign outcome_o       = otmo_q;
  assign frame_byte_o    = otmo_q ? 8'd0 : rd_data_q;
  assign byte_position_o = opos_q[3:0];
  assign last_of_run_o   = olast_q;

  // a new run never lands on one still being read out
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_i.start |-> !busy_q) else $error("run started while busy");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pos_q < len_q)) else $error("run position past length");

  // collection must use the other bank while a frame is read out
  a_bank_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && busy_q && !tmo_q) |-> (wr_bank_i != bank_q))
    else $error("write into bank being read");

  a_tmo_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && otmo_q) |-> olast_q) else $error("timeout not last of run");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && run_last) |=> !busy_q) else $error("run did not end");

endmodule

// ===== hdl/servo_reply_frame_receiver.sv =====
// servo_reply_frame_receiver: top level, config registers and frame parser
// depends on srfr_pkg and srfr_emitter
// result path: the item that completes a valid frame, or a timeout item, starts a run in
//   the emitter (busy_q); its first byte is then read into the output register and offered
// throughput: one input item per cycle; in_ready_o drops only for an item that would
//   open a new result run while the previous run is still being read from the buffer;
//   a run of n bytes leaves at one per cycle while out_ready_i is high
// reset: registers return to their defaults and the receiver is idle; the frame buffer
//   is not cleared, since only bytes of the current frame are ever read back
module servo_reply_frame_receiver #(
  parameter int unsigned MAX_FRAME = srfr_pkg::MaxFrameDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  rx_byte_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        outcome_o,
  output logic [7:0]  frame_byte_o,
  output logic [3:0]  byte_position_o,
  output logic        last_of_run_o
);

  localparam int unsigned LenW  = srfr_pkg::LenW;
  localparam int unsigned TickW = srfr_pkg::TickW;
  // longest frame the buffer can hold, capped by the length register width
  localparam logic [LenW-1:0] MaxLen = LenW'((MAX_FRAME > 31) ? 31 : MAX_FRAME);

  // configuration registers
  logic [7:0]       dev_addr_q;
  logic [7:0]       exp_func_q;
  logic [LenW-1:0]  frame_len_q;
  logic [TickW-1:0] timeout_q;
  logic             cfg_we;

  // receiver state
  logic             armed_q,   armed_d;
  logic [LenW-1:0]  held_q,    held_d;
  logic [7:0]       sum_q,     sum_d;
  logic [TickW-1:0] elapsed_q, elapsed_d;
  logic             bank_q,    bank_d;
  logic [7:0]       byte1_q,   byte1_d;

  logic [LenW-1:0]  len_eff;
  logic [LenW-1:0]  held_inc;
  logic [TickW-1:0] elapsed_inc;
  logic             hdr;
  logic             resync;
  logic             wr_en;
  logic [LenW-1:0]  wr_idx;
  logic             emit_req;
  logic             emit_tmo;
  logic             acc;
  logic             busy;

  srfr_pkg::run_req_t run_req;

  // ---------------------------------------------------------------------------
  // configuration port: always ready, written in the access phase
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= srfr_pkg::DevAddrRst;
      exp_func_q  <= srfr_pkg::ExpFuncRst;
      frame_len_q <= srfr_pkg::FrameLenRst;
      timeout_q   <= srfr_pkg::TimeoutRst;
    end else if (cfg_we) begin
      unique case (srfr_pkg::reg_e'(paddr[3:2]))
        srfr_pkg::RegDevAddr:  dev_addr_q  <= pwdata[7:0];
        srfr_pkg::RegExpFunc:  exp_func_q  <= pwdata[7:0];
        srfr_pkg::RegFrameLen: frame_len_q <= pwdata[LenW-1:0];
        srfr_pkg::RegTimeout:  timeout_q   <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (srfr_pkg::reg_e'(paddr[3:2]))
      srfr_pkg::RegDevAddr:  prdata = {24'd0, dev_addr_q};
      srfr_pkg::RegExpFunc:  prdata = {24'd0, exp_func_q};
      srfr_pkg::RegFrameLen: prdata = {27'd0, frame_len_q};
      srfr_pkg::RegTimeout:  prdata = {12'd0, timeout_q};
      default:               prdata = '0;
    endcase
  end

  // frame length clamped to what the format and the buffer allow
  always_comb begin
    if (frame_len_q < srfr_pkg::MinLen) begin
      len_eff = srfr_pkg::MinLen;
    end else if (frame_len_q > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = frame_len_q;
    end
  end

  // ---------------------------------------------------------------------------
  // frame parser: unless in_ready_o holds an item off, one item handled per cycle
  // ---------------------------------------------------------------------------
  assign held_inc    = held_q + 5'd1;
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 20'd1;
  assign hdr         = (rx_byte_i == srfr_pkg::HdrByte);

  always_comb begin
    armed_d   = armed_q;
    held_d    = held_q;
    sum_d     = sum_q;
    elapsed_d = elapsed_q;
    bank_d    = bank_q;
    byte1_d   = byte1_q;
    resync    = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = held_q;
    emit_req  = 1'b0;
    emit_tmo  = 1'b0;
    case (func_i)
      srfr_pkg::FuncStart: begin
        // restart the wait, any partial frame is dropped
        armed_d   = 1'b1;
        held_d    = '0;
        sum_d     = '0;
        elapsed_d = '0;
      end
      srfr_pkg::FuncByte: begin
        if (armed_q) begin
          wr_en = 1'b1;
          if (held_q == '0 || held_q >= len_eff) begin
            // hunting for a header, or count left over from a longer length
            resync = 1'b1;
          end else if (held_inc == 5'd3 &&
                       (byte1_q != dev_addr_q || rx_byte_i != exp_func_q)) begin
            resync = 1'b1;
          end else if (held_inc == len_eff) begin
            if (sum_q == rx_byte_i) begin
              // good frame: hand the bank over and collect into the other one
              armed_d  = 1'b0;
              held_d   = '0;
              sum_d    = '0;
              emit_req = 1'b1;
              bank_d   = ~bank_q;
            end else begin
              resync = 1'b1;
            end
          end else begin
            held_d = held_inc;
            sum_d  = sum_q + rx_byte_i;
            if (held_q == 5'd1) begin
              byte1_d = rx_byte_i;
            end
          end
          if (resync) begin
            // keep a header byte as the start of a new frame
            wr_idx = '0;
            held_d = hdr ? 5'd1 : 5'd0;
            sum_d  = hdr ? srfr_pkg::HdrByte : 8'd0;
          end
        end
      end
      srfr_pkg::FuncTick: begin
        if (armed_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= timeout_q) begin
            armed_d  = 1'b0;
            held_d   = '0;
            sum_d    = '0;
            emit_req = 1'b1;
            emit_tmo = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // hold off only an item that opens a run while the last one drains
  assign in_ready_o = !(busy && emit_req);
  assign acc        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      held_q    <= '0;
      sum_q     <= '0;
      elapsed_q <= '0;
      bank_q    <= 1'b0;
    end else if (acc) begin
      armed_q   <= armed_d;
      held_q    <= held_d;
      sum_q     <= sum_d;
      elapsed_q <= elapsed_d;
      bank_q    <= bank_d;
    end
  end

  // address byte kept aside for the check at the function code
  always_ff @(posedge clk_i) begin
    if (acc) begin
      byte1_q <= byte1_d;
    end
  end

  assign run_req.start = acc && emit_req;
  assign run_req.tmo   = emit_tmo;
  assign run_req.bank  = bank_q;
  assign run_req.len   = emit_tmo ? 5'd1 : len_eff;

  // ---------------------------------------------------------------------------
  // frame buffer and result sequencer
  // ---------------------------------------------------------------------------
  srfr_emitter #(
    .MAX_FRAME (MAX_FRAME)
  ) u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .run_i           (run_req),
    .wr_en_i         (acc && wr_en),
    .wr_bank_i       (bank_q),
    .wr_idx_i        (wr_idx),
    .wr_data_i       (rx_byte_i),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .outcome_o       (outcome_o),
    .frame_byte_o    (frame_byte_o),
    .byte_position_o (byte_position_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule
